// ----- design/uule_pkg.sv -----
// Package for the uuencode line encoder.
// Holds the payload structs, the line descriptor, the back-end state type and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uule_pkg;

	localparam int CNT_W = 6;
	localparam int GRP_W = 4;
	localparam int WORD_W = 24;

	localparam logic [6:0] CHAR_OFFSET = 7'd32;
	localparam logic [6:0] NEWLINE_CHAR = 7'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       line_done;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		logic [GRP_W-1:0] last_grp;
	} line_desc_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_LEN,
		B_DATA,
		B_NL
	} back_state_t;

endpackage

`default_nettype wire

// ----- design/uuencode_line_encoder_top.sv -----
// uuencode line encoder, top level. The byte that closes a line passes the descriptor
// queue and the back-end B_IDLE and B_LEN states before its first char is registered.
// Throughput: one byte per cycle into the front while a store bank is free; the back
// sends one char per cycle while the output port is ready, with an idle state between lines.
// Two store banks: the front stalls while two closed lines wait or are being sent.
// Reset (arst_n low, asynchronous) empties the queue and clears all counters; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module uuencode_line_encoder_top #(
	parameter int LINE_CHARS = 60
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire uule_pkg::in_item_t  byte_item,
	output logic                     char_valid,
	input  wire logic                char_ready,
	output uule_pkg::out_item_t      char_item
);

	import uule_pkg::*;

	localparam int GROUPS = LINE_CHARS / 4;
	localparam int LINE_BYTES = GROUPS * 3;
	localparam int MEM_DEPTH = 2 * GROUPS;
	localparam int ADDR_W = $clog2(MEM_DEPTH);

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              push;
	line_desc_t        push_desc;
	logic              pop;
	logic              head_valid;
	line_desc_t        head_desc;
	logic              line_free;

	uule_front #(
		.LINE_BYTES(LINE_BYTES),
		.ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.push(push),
		.push_desc(push_desc),
		.line_free(line_free)
	);

	uule_store #(
		.DEPTH(MEM_DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(WORD_W)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	uule_desc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_desc(push_desc),
		.pop(pop),
		.head_valid(head_valid),
		.head_desc(head_desc)
	);

	uule_back #(
		.ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_desc(head_desc),
		.pop(pop),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.line_free(line_free),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item)
	);

endmodule

`default_nettype wire

// ----- design/uule_store.sv -----
// Two-bank line store: one 24-bit word per three-byte group.
// One write port, one read port with registered read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module uule_store #(
	parameter int DEPTH = 30,
	parameter int ADDR_W = 5,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/uule_front.sv -----
// Front end: takes bytes, packs them into groups, writes the store and closes lines.
// Depends on uule_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uule_front #(
	parameter int LINE_BYTES = 45,
	parameter int ADDR_W = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	output logic                         byte_ready,
	input  wire uule_pkg::in_item_t      byte_item,
	output logic                         wr_en,
	output logic [ADDR_W-1:0]            wr_addr,
	output logic [uule_pkg::WORD_W-1:0]  wr_data,
	output logic                         push,
	output uule_pkg::line_desc_t         push_desc,
	input  wire logic                    line_free
);

	import uule_pkg::*;

	logic [WORD_W-1:0] acc_q;
	logic [1:0]        bpos_q;
	logic [GRP_W-1:0]  grp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              bank_q;
	logic [1:0]        held_q;

	logic              take;
	logic [WORD_W-1:0] new_word;
	logic [CNT_W-1:0]  cnt_n;
	logic              line_end;
	logic              grp_end;

	assign byte_ready = (held_q != 2'd2);
	assign take = byte_valid && byte_ready;

	always_comb begin
		case (bpos_q)
			2'd0: new_word = {byte_item.data_byte, 16'd0};
			2'd1: new_word = {acc_q[23:16], byte_item.data_byte, 8'd0};
			2'd2: new_word = {acc_q[23:8], byte_item.data_byte};
			default: new_word = {byte_item.data_byte, 16'd0};
		endcase
	end

	assign cnt_n = cnt_q + CNT_W'(1);
	assign line_end = byte_item.end_of_data || (cnt_n == CNT_W'(LINE_BYTES));
	assign grp_end = (bpos_q == 2'd2) || line_end;

	assign wr_en = take && grp_end;
	assign wr_addr = ADDR_W'({grp_q, bank_q});
	assign wr_data = new_word;

	assign push = take && line_end;
	assign push_desc.byte_count = cnt_n;
	assign push_desc.last_grp = grp_q;

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q <= 2'd0;
			grp_q <= '0;
			cnt_q <= '0;
			bank_q <= 1'b0;
		end else if (take) begin
			if (line_end) begin
				bpos_q <= 2'd0;
				grp_q <= '0;
				cnt_q <= '0;
				bank_q <= !bank_q;
			end else begin
				cnt_q <= cnt_n;
				if (grp_end) begin
					bpos_q <= 2'd0;
					grp_q <= grp_q + GRP_W'(1);
				end else begin
					bpos_q <= bpos_q + 2'd1;
				end
			end
		end
	end

	// lines held in the store: queued or being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else begin
			held_q <= held_q + {1'b0, push} - {1'b0, line_free};
		end
	end

`ifndef ASSERT_OFF
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3) else $error("front: more lines held than banks");
`endif

endmodule

`default_nettype wire

// ----- design/uule_desc_fifo.sv -----
// Two-entry queue of closed-line descriptors between front and back.
// Depends on uule_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uule_desc_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire uule_pkg::line_desc_t push_desc,
	input  wire logic                 pop,
	output logic                      head_valid,
	output uule_pkg::line_desc_t      head_desc
);

	import uule_pkg::*;

	line_desc_t ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head_desc = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2 || pop)) else $error("desc queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("desc queue underflow");
`endif

endmodule

`default_nettype wire

// ----- design/uule_back.sv -----
// Back end: sends one line per descriptor: length char, four chars per group, newline.
// Reads group words from the store; output register toward the consumer. Depends on uule_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uule_back #(
	parameter int ADDR_W = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_valid,
	input  wire uule_pkg::line_desc_t    head_desc,
	output logic                         pop,
	output logic [ADDR_W-1:0]            rd_addr,
	input  wire logic [uule_pkg::WORD_W-1:0] rd_data,
	output logic                         line_free,
	output logic                         char_valid,
	input  wire logic                    char_ready,
	output uule_pkg::out_item_t          char_item
);

	import uule_pkg::*;

	back_state_t state_q, state_d;
	line_desc_t  desc_q;
	logic [GRP_W-1:0] grp_q, grp_d;
	logic [1:0]  chr_q, chr_d;
	logic        bank_q, bank_d;
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic        take;
	logic        emit;
	out_item_t   emit_item;
	logic [5:0]  sextet;

	assign take = !out_valid_q || char_ready;

	always_comb begin
		case (chr_q)
			2'd0: sextet = rd_data[23:18];
			2'd1: sextet = rd_data[17:12];
			2'd2: sextet = rd_data[11:6];
			2'd3: sextet = rd_data[5:0];
			default: sextet = rd_data[23:18];
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_valid) state_d = B_LEN;
			end
			B_LEN: begin
				if (take) state_d = B_DATA;
			end
			B_DATA: begin
				if (take && chr_q == 2'd3 && grp_q == desc_q.last_grp) state_d = B_NL;
			end
			B_NL: begin
				if (take) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		emit = 1'b0;
		emit_item = '{out_char: NEWLINE_CHAR, line_done: 1'b1};
		grp_d = grp_q;
		chr_d = chr_q;
		bank_d = bank_q;
		line_free = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = head_valid;
				grp_d = '0;
				chr_d = 2'd0;
			end
			B_LEN: begin
				emit = take;
				emit_item = '{out_char: 7'(desc_q.byte_count) + CHAR_OFFSET, line_done: 1'b0};
			end
			B_DATA: begin
				emit = take;
				emit_item = '{out_char: {1'b0, sextet} + CHAR_OFFSET, line_done: 1'b0};
				if (take) begin
					chr_d = chr_q + 2'd1;
					if (chr_q == 2'd3 && grp_q != desc_q.last_grp) grp_d = grp_q + GRP_W'(1);
				end
			end
			B_NL: begin
				emit = take;
				if (take) begin
					bank_d = !bank_q;
					line_free = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign rd_addr = ADDR_W'({grp_d, bank_d});

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head_desc;
		end
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			grp_q <= '0;
			chr_q <= 2'd0;
			bank_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			grp_q <= grp_d;
			chr_q <= chr_d;
			bank_q <= bank_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign char_valid = out_valid_q;
	assign char_item = out_item_q;

`ifndef ASSERT_OFF
	a_done_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.line_done) |-> (out_item_q.out_char == NEWLINE_CHAR))
		else $error("back: line_done without newline");
	a_grp_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DATA) |-> (grp_q <= desc_q.last_grp))
		else $error("back: group index past end of line");
`endif

endmodule

`default_nettype wire
